FILE: src/stis_pkg.sv
`default_nettype none

package stis_pkg;

	// Default table capacity
	localparam int DEPTH_DEF = 64;

	// Field widths of the channels
	localparam int KEY_W   = 32;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_BAD_POS   = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SEARCH_RD,
		S_SEARCH_CMP,
		S_UP_RD,
		S_UP_WR,
		S_FETCH_RD,
		S_FETCH_WAIT,
		S_DOWN_RD,
		S_DOWN_WR,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    capture;
		logic    search_read;
		logic    search_step;
		logic    idx_from_count;
		logic    idx_from_pos;
		logic    up_read;
		logic    up_write;
		logic    put;
		logic    down_read;
		logic    down_write;
		logic    fetch_read;
		logic    fetch_take;
		logic    count_dec;
		logic    load_result;
		status_t res_status;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic pos_bad;
		logic search_done;
		logic up_done;
		logic down_done;
		logic key_found;
		logic out_busy;
	} stat_t;

endpackage

`default_nettype wire

FILE: src/stis_req_if.sv
`default_nettype none

interface stis_req_if;
	logic                         valid;
	logic                         ready;
	stis_pkg::op_t                op;
	logic signed [stis_pkg::KEY_W-1:0] key;
	logic [stis_pkg::POS_W-1:0]   position;

	modport source (output valid, output op, output key, output position, input ready);
	modport sink   (input valid, input op, input key, input position, output ready);
endinterface

`default_nettype wire

FILE: src/stis_rsp_if.sv
`default_nettype none

interface stis_rsp_if;
	logic                              valid;
	logic                              ready;
	stis_pkg::status_t                 status;
	logic [stis_pkg::POS_W-1:0]        found_position;
	logic signed [stis_pkg::KEY_W-1:0] key_out;
	logic [stis_pkg::COUNT_W-1:0]      entry_count;

	modport source (output valid, output status, output found_position, output key_out,
		output entry_count, input ready);
	modport sink   (input valid, input status, input found_position, input key_out,
		input entry_count, output ready);
endinterface

`default_nettype wire

FILE: src/stis_ram.sv
`default_nettype none

module stis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/stis_ctrl.sv
`default_nettype none

module stis_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire stis_pkg::stat_t stat,
	output stis_pkg::cmd_t       cmd
);

	import stis_pkg::*;

	state_t  state_q, state_d;
	status_t res_status_q, res_status_d;

	// State and pending status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_status_q <= ST_OK;
		end else begin
			state_q      <= state_d;
			res_status_q <= res_status_d;
		end
	end

	// Sequence one operation at a time
	always_comb begin
		state_d        = state_q;
		res_status_d   = res_status_q;
		cmd            = '0;
		cmd.res_status = res_status_q;
		in_ready       = 1'b0;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end

			S_DECODE: begin
				res_status_d = ST_OK;
				case (stat.op)
					OP_INSERT: begin
						if (stat.full) begin
							res_status_d = ST_FULL;
							state_d      = S_RESP;
						end else begin
							state_d = S_SEARCH_RD;
						end
					end
					OP_FIND: begin
						if (stat.empty) begin
							res_status_d = ST_EMPTY;
							state_d      = S_RESP;
						end else begin
							state_d = S_SEARCH_RD;
						end
					end
					default: begin
						if (stat.empty) begin
							res_status_d = ST_EMPTY;
							state_d      = S_RESP;
						end else if (stat.pos_bad) begin
							res_status_d = ST_BAD_POS;
							state_d      = S_RESP;
						end else begin
							state_d = S_FETCH_RD;
						end
					end
				endcase
			end

			// Lower-bound search: each probe reads the table, then compares
			S_SEARCH_RD: begin
				if (stat.search_done) begin
					if (stat.op == OP_INSERT) begin
						cmd.idx_from_count = 1'b1;
						state_d            = S_UP_RD;
					end else begin
						res_status_d = stat.key_found ? ST_OK : ST_NOT_FOUND;
						state_d      = S_RESP;
					end
				end else begin
					cmd.search_read = 1'b1;
					state_d         = S_SEARCH_CMP;
				end
			end

			S_SEARCH_CMP: begin
				cmd.search_step = 1'b1;
				state_d         = S_SEARCH_RD;
			end

			// Move larger keys up, then drop the new key into the gap
			S_UP_RD: begin
				if (stat.up_done) begin
					cmd.put = 1'b1;
					state_d = S_RESP;
				end else begin
					cmd.up_read = 1'b1;
					state_d     = S_UP_WR;
				end
			end

			S_UP_WR: begin
				cmd.up_write = 1'b1;
				state_d      = S_UP_RD;
			end

			S_FETCH_RD: begin
				cmd.fetch_read = 1'b1;
				state_d        = S_FETCH_WAIT;
			end

			S_FETCH_WAIT: begin
				cmd.fetch_take = 1'b1;
				if (stat.op == OP_REMOVE) begin
					cmd.idx_from_pos = 1'b1;
					state_d          = S_DOWN_RD;
				end else begin
					state_d = S_RESP;
				end
			end

			// Close the gap left by a removed entry
			S_DOWN_RD: begin
				if (stat.down_done) begin
					cmd.count_dec = 1'b1;
					state_d       = S_RESP;
				end else begin
					cmd.down_read = 1'b1;
					state_d       = S_DOWN_WR;
				end
			end

			S_DOWN_WR: begin
				cmd.down_write = 1'b1;
				state_d        = S_DOWN_RD;
			end

			// Hand the result beat to the output register once it is free
			S_RESP: begin
				if (!stat.out_busy) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/stis_dp.sv
`default_nettype none

module stis_dp #(
	parameter int DEPTH = stis_pkg::DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire stis_pkg::cmd_t                    cmd,
	output stis_pkg::stat_t                        stat,
	input  wire stis_pkg::op_t                     in_op,
	input  wire logic signed [stis_pkg::KEY_W-1:0] in_key,
	input  wire logic [stis_pkg::POS_W-1:0]        in_position,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output stis_pkg::status_t                      out_status,
	output logic [stis_pkg::POS_W-1:0]             out_found_position,
	output logic signed [stis_pkg::KEY_W-1:0]      out_key_out,
	output logic [stis_pkg::COUNT_W-1:0]           out_entry_count
);

	import stis_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int PW   = (AW > POS_W) ? AW : POS_W;
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam int EW   = (CW > COUNT_W) ? CW : COUNT_W;

	op_t                     op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [POS_W-1:0]        pos_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           lo_q, hi_q, idx_q;
	logic                    eq_q;
	logic signed [KEY_W-1:0] kout_q;
	logic                    out_valid_q;

	logic [CW-1:0]    mid;
	logic [CW-1:0]    idx_dn, idx_up;
	logic [PW-1:0]    pos_ext;
	logic [AW-1:0]    pos_addr;
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [KEY_W-1:0] ram_wdata, ram_rdata;
	logic             key_less;
	logic [PW-1:0]    lo_ext;
	logic [EW-1:0]    count_ext;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_dn   = idx_q - CW'(1);
	assign idx_up   = idx_q + CW'(1);
	assign pos_ext  = PW'(pos_q);
	assign pos_addr = pos_ext[AW-1:0];
	assign key_less = $signed(ram_rdata) < key_q;

	// Status towards the controller
	always_comb begin
		stat             = '0;
		stat.op          = op_q;
		stat.full        = (count_q == CW'(DEPTH));
		stat.empty       = (count_q == '0);
		stat.pos_bad     = (CMPW'(pos_q) >= CMPW'(count_q));
		stat.search_done = (lo_q >= hi_q);
		stat.up_done     = (idx_q == lo_q);
		stat.down_done   = (idx_up >= count_q);
		stat.key_found   = eq_q;
		stat.out_busy    = out_valid_q && !out_ready;
	end

	// Table port selection
	always_comb begin
		ram_re    = cmd.search_read | cmd.up_read | cmd.down_read | cmd.fetch_read;
		ram_raddr = mid[AW-1:0];
		if (cmd.up_read) begin
			ram_raddr = idx_dn[AW-1:0];
		end else if (cmd.down_read) begin
			ram_raddr = idx_up[AW-1:0];
		end else if (cmd.fetch_read) begin
			ram_raddr = pos_addr;
		end

		ram_we    = cmd.up_write | cmd.down_write | cmd.put;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		if (cmd.put) begin
			ram_waddr = lo_q[AW-1:0];
			ram_wdata = key_q;
		end
	end

	stis_ram #(
		.WIDTH(KEY_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Capture the request beat, then narrow the search window
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= in_op;
			key_q <= in_key;
			pos_q <= in_position;
			lo_q  <= '0;
			hi_q  <= count_q;
			eq_q  <= 1'b0;
		end else if (cmd.search_step) begin
			if (key_less) begin
				lo_q <= mid + CW'(1);
			end else begin
				hi_q <= mid;
				eq_q <= (ram_rdata == key_q);
			end
		end
	end

	// Shift cursor
	always_ff @(posedge clk) begin
		if (cmd.idx_from_count) begin
			idx_q <= count_q;
		end else if (cmd.idx_from_pos) begin
			idx_q <= CW'(pos_addr);
		end else if (cmd.up_write) begin
			idx_q <= idx_dn;
		end else if (cmd.down_write) begin
			idx_q <= idx_up;
		end
	end

	// Hold the key that was read or removed
	always_ff @(posedge clk) begin
		if (cmd.fetch_take) begin
			kout_q <= $signed(ram_rdata);
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.put) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.count_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign lo_ext    = PW'(lo_q[AW-1:0]);
	assign count_ext = EW'(count_q);

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_status      <= cmd.res_status;
			out_entry_count <= count_ext[COUNT_W-1:0];
			if (cmd.res_status != ST_OK) begin
				out_found_position <= '0;
				out_key_out        <= '0;
			end else if (op_q == OP_INSERT || op_q == OP_FIND) begin
				out_found_position <= lo_ext[POS_W-1:0];
				out_key_out        <= '0;
			end else begin
				out_found_position <= pos_q;
				out_key_out        <= kout_q;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: src/sorted_table_insert_search_unit.sv
`default_nettype none
// Sorted key table: one operation in flight, results through an output register.
// Find: lower-bound binary search of the n entries held, a registered table read and a
// compare per probe. Insert: search, move each larger key up (read, then write), write the
// new key into the gap. Read: fetch one entry. Remove: fetch it, move later keys down. The
// next request beat is taken once the result is registered.
// Reset clears the entry count and the result valid; table contents are not cleared.

module sorted_table_insert_search_unit #(
	parameter int DEPTH = stis_pkg::DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	stis_req_if.sink req,
	stis_rsp_if.source rsp
);

	import stis_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	stis_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	stis_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.in_op             (req.op),
		.in_key            (req.key),
		.in_position       (req.position),
		.out_valid         (rsp.valid),
		.out_ready         (rsp.ready),
		.out_status        (rsp.status),
		.out_found_position(rsp.found_position),
		.out_key_out       (rsp.key_out),
		.out_entry_count   (rsp.entry_count)
	);

endmodule

`default_nettype wire

FILE: dv/sorted_table_insert_search_unit_test.sv
`default_nettype none

module sorted_table_insert_search_unit_test;
	import stis_pkg::*;

	localparam int TABLE_DEPTH = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 600;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	typedef struct packed {
		status_t              status;
		logic [POS_W-1:0]     found_position;
		logic signed [KEY_W-1:0] key_out;
		logic [COUNT_W-1:0]   entry_count;
	} table_result_t;

	typedef struct packed {
		op_t                  op;
		logic signed [KEY_W-1:0] key;
		logic [POS_W-1:0]     position;
		logic                 typed;
		table_result_t        result;
	} probe_row_t;

	logic clk;
	logic arst_n;

	stis_req_if req_ch ();
	stis_rsp_if rsp_ch ();

	sorted_table_insert_search_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow copy of the table and its entry count
	logic signed [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
	int unsigned shadow_count;
	int unsigned peak_count;

	table_result_t expected_q [$];
	int mismatches;
	int results_seen;
	int requests_sent;
	int src_idle_pct;
	int sink_stall_pct;
	int full_hits;
	int empty_hits;
	int miss_hits;
	int bad_pos_hits;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Apply one operation to the shadow table and return what the block must answer
	function automatic table_result_t table_step(op_t op, logic signed [KEY_W-1:0] key,
		logic [POS_W-1:0] position);
		table_result_t r;
		int unsigned slot;
		r = '0;
		r.status = ST_OK;
		slot = 0;
		case (op)
			OP_INSERT: begin
				if (shadow_count >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					while (slot < shadow_count && shadow_keys[slot] < key)
						slot++;
					for (int i = shadow_count; i > slot; i--)
						shadow_keys[i] = shadow_keys[i-1];
					shadow_keys[slot] = key;
					shadow_count++;
					r.found_position = POS_W'(slot);
				end
			end
			OP_FIND: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					while (slot < shadow_count && shadow_keys[slot] < key)
						slot++;
					if (slot < shadow_count && shadow_keys[slot] == key)
						r.found_position = POS_W'(slot);
					else
						r.status = ST_NOT_FOUND;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else if (position >= shadow_count) begin
					r.status = ST_BAD_POS;
				end else begin
					r.key_out = shadow_keys[position];
					r.found_position = position;
					if (op == OP_REMOVE) begin
						for (int i = position; i + 1 < shadow_count; i++)
							shadow_keys[i] = shadow_keys[i+1];
						shadow_count--;
					end
				end
			end
		endcase
		r.entry_count = COUNT_W'(shadow_count);
		return r;
	endfunction

	// Mostly keys that collide or sit in the table, some extremes, the rest anything
	function automatic logic signed [KEY_W-1:0] pick_key();
		int unsigned r;
		int s;
		r = $urandom_range(99, 0);
		s = int'($urandom_range(6, 0)) - 3;
		if (r < 25)
			return KEY_W'(s * 32768);
		if (r < 50 && shadow_count > 0)
			return shadow_keys[$urandom_range(shadow_count - 1, 0)];
		if (r < 65) begin
			case ($urandom_range(4, 0))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return '0;
				3: return -1;
				default: return 1;
			endcase
		end
		return $urandom;
	endfunction

	// Mostly live positions, some just past the end, some anywhere
	function automatic logic [POS_W-1:0] pick_position();
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 60 && shadow_count > 0)
			return POS_W'($urandom_range(shadow_count - 1, 0));
		if (r < 75)
			return POS_W'(shadow_count);
		return POS_W'($urandom_range(63, 0));
	endfunction

	function automatic op_t pick_op(traffic_mode_t mode);
		int unsigned r;
		r = $urandom_range(99, 0);
		case (mode)
			MODE_FILL:  return r < 80 ? OP_INSERT : r < 90 ? OP_FIND : r < 95 ? OP_READ : OP_REMOVE;
			MODE_DRAIN: return r < 75 ? OP_REMOVE : r < 85 ? OP_READ : r < 95 ? OP_FIND : OP_INSERT;
			default:    return op_t'($urandom_range(3, 0));
		endcase
	endfunction

	// Rotate through the idling mixes every forty requests
	function automatic void set_pressure(int idx);
		case ((idx / 40) % 5)
			1: begin src_idle_pct = 61; sink_stall_pct = 0; end
			2: begin src_idle_pct = 0; sink_stall_pct = 61; end
			3: begin src_idle_pct = 36; sink_stall_pct = 36; end
			default: begin src_idle_pct = 0; sink_stall_pct = 0; end
		endcase
	endfunction

	// Drive one request beat, hold it until taken, then queue its answer
	task automatic issue(op_t op, logic signed [KEY_W-1:0] key, logic [POS_W-1:0] position,
		logic typed, table_result_t typed_result);
		table_result_t predicted;
		set_pressure(requests_sent);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.key <= key;
		req_ch.position <= position;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = table_step(op, key, position);
		case (predicted.status)
			ST_FULL:      full_hits++;
			ST_EMPTY:     empty_hits++;
			ST_NOT_FOUND: miss_hits++;
			ST_BAD_POS:   bad_pos_hits++;
			default:      ;
		endcase
		if (shadow_count > peak_count)
			peak_count = shadow_count;
		expected_q.push_back(typed ? typed_result : predicted);
		requests_sent++;
	endtask

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin : result_check
		table_result_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat %0d arrived with nothing outstanding", results_seen);
			end else begin
				want = expected_q.pop_front();
				if (rsp_ch.status != want.status || rsp_ch.found_position != want.found_position
					|| rsp_ch.key_out != want.key_out || rsp_ch.entry_count != want.entry_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected %s pos %0d key %0d count %0d, got %s pos %0d key %0d count %0d",
							results_seen, want.status.name(), want.found_position, want.key_out,
							want.entry_count, rsp_ch.status.name(), rsp_ch.found_position,
							rsp_ch.key_out, rsp_ch.entry_count);
				end
			end
		end
		rsp_ch.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
	end

	// End the run if neither channel moves a beat for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no handshake for %0d cycles", QUIET_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		probe_row_t directed [22];
		traffic_mode_t mode;
		int tail;
		int mixed_left;
		int start_count;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_INSERT;
		req_ch.key = '0;
		req_ch.position = '0;
		rsp_ch.ready = 1'b0;
		shadow_count = 0;
		peak_count = 0;
		mismatches = 0;
		results_seen = 0;
		requests_sent = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		full_hits = 0;
		empty_hits = 0;
		miss_hits = 0;
		bad_pos_hits = 0;

		// Empty table, both extremes, duplicates, misses and out-of-range positions
		directed = '{
			'{OP_FIND,   32'sd0,          6'd0,  1'b1, '{ST_EMPTY,     6'd0, 32'sd0,  7'd0}},
			'{OP_REMOVE, 32'sd0,          6'd0,  1'b1, '{ST_EMPTY,     6'd0, 32'sd0,  7'd0}},
			'{OP_READ,   KEY_MAX,         6'd63, 1'b1, '{ST_EMPTY,     6'd0, 32'sd0,  7'd0}},
			'{OP_INSERT, KEY_MAX,         6'd63, 1'b1, '{ST_OK,        6'd0, 32'sd0,  7'd1}},
			'{OP_INSERT, KEY_MIN,         6'd0,  1'b1, '{ST_OK,        6'd0, 32'sd0,  7'd2}},
			'{OP_INSERT, 32'sd0,          6'd0,  1'b1, '{ST_OK,        6'd1, 32'sd0,  7'd3}},
			'{OP_INSERT, 32'sd0,          6'd0,  1'b1, '{ST_OK,        6'd1, 32'sd0,  7'd4}},
			'{OP_INSERT, 32'sh0001_8000,  6'd0,  1'b1, '{ST_OK,        6'd3, 32'sd0,  7'd5}},
			'{OP_FIND,   32'sd0,          6'd0,  1'b1, '{ST_OK,        6'd1, 32'sd0,  7'd5}},
			'{OP_FIND,   KEY_MAX,         6'd0,  1'b1, '{ST_OK,        6'd4, 32'sd0,  7'd5}},
			'{OP_FIND,   KEY_MIN,         6'd0,  1'b1, '{ST_OK,        6'd0, 32'sd0,  7'd5}},
			'{OP_FIND,   32'sd1,          6'd0,  1'b1, '{ST_NOT_FOUND, 6'd0, 32'sd0,  7'd5}},
			'{OP_FIND,   -32'sd1,         6'd0,  1'b1, '{ST_NOT_FOUND, 6'd0, 32'sd0,  7'd5}},
			'{OP_READ,   32'sd0,          6'd5,  1'b1, '{ST_BAD_POS,   6'd0, 32'sd0,  7'd5}},
			'{OP_READ,   32'sd0,          6'd63, 1'b1, '{ST_BAD_POS,   6'd0, 32'sd0,  7'd5}},
			'{OP_REMOVE, 32'sd0,          6'd5,  1'b1, '{ST_BAD_POS,   6'd0, 32'sd0,  7'd5}},
			'{OP_READ,   32'sd0,          6'd4,  1'b1, '{ST_OK,        6'd4, KEY_MAX, 7'd5}},
			'{OP_READ,   32'sd0,          6'd0,  1'b1, '{ST_OK,        6'd0, KEY_MIN, 7'd5}},
			'{OP_REMOVE, 32'sd0,          6'd0,  1'b1, '{ST_OK,        6'd0, KEY_MIN, 7'd4}},
			'{OP_REMOVE, 32'sd0,          6'd3,  1'b1, '{ST_OK,        6'd3, KEY_MAX, 7'd3}},
			'{OP_READ,   32'sd0,          6'd2,  1'b0, '0},
			'{OP_INSERT, 32'shFFFF_0000,  6'd0,  1'b0, '0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			issue(directed[i].op, directed[i].key, directed[i].position, directed[i].typed,
				directed[i].result);

		// Fill, mix, then drain or fill again by table level until enough requests are out
		mode = MODE_FILL;
		while (requests_sent < RANDOM_ITEMS + $size(directed)) begin
			start_count = requests_sent;
			tail = 0;
			mixed_left = 60;
			while (1) begin
				if (mode == MODE_FILL && shadow_count >= TABLE_DEPTH)
					tail++;
				if (mode == MODE_DRAIN && shadow_count == 0)
					tail++;
				if (tail > 8 || (mode == MODE_MIXED && mixed_left == 0)
					|| requests_sent - start_count > 300)
					break;
				mixed_left--;
				issue(pick_op(mode), pick_key(), pick_position(), 1'b0, '0);
			end
			case (mode)
				MODE_FILL:  mode = MODE_MIXED;
				MODE_DRAIN: mode = MODE_FILL;
				default:    mode = (shadow_count > TABLE_DEPTH / 2) ? MODE_DRAIN : MODE_FILL;
			endcase
		end
		req_ch.valid <= 1'b0;

		// Let the last answers come home
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests answered, table peaked at %0d entries", results_seen, peak_count);
		$display("refusals seen: full %0d, empty %0d, not found %0d, bad position %0d",
			full_hits, empty_hits, miss_hits, bad_pos_hits);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
